/* src/qvr_pkg.sv */
package qvr_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 2;
  localparam int OUT_SHIFT  = 2 * FRAC_BITS;

  // Product of a quaternion component and a vector component.
  localparam int QV_W  = 2 * DATA_WIDTH;
  // Sum of three such products.
  localparam int P_W   = QV_W + 1;
  // Product of an intermediate component and a quaternion component.
  localparam int PQ_W  = P_W + DATA_WIDTH;
  // Sum of four such products.
  localparam int ACC_W = PQ_W + 2;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

  localparam logic signed [DATA_WIDTH-1:0] ROT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] ROT_MIN = ~ROT_MAX;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] rot_x;
    logic signed [DATA_WIDTH-1:0] rot_y;
    logic signed [DATA_WIDTH-1:0] rot_z;
    logic                         overflow;
  } result_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] w;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] z;
  } quat_t;

endpackage

/* src/qvr_round_sat.sv */
module qvr_round_sat
  import qvr_pkg::*;
(
  input  logic signed [ACC_W-1:0]      acc,
  output logic signed [DATA_WIDTH-1:0] rot,
  output logic                         sat
);

  logic signed [ACC_W-1:0] biased;
  logic signed [ACC_W-1:0] shifted;

  // Round to nearest with ties upward, then clamp to the output range.
  always_comb begin
    biased  = acc + ROUND_HALF;
    shifted = biased >>> OUT_SHIFT;
    if (shifted > SAT_MAX) begin
      rot = ROT_MAX;
      sat = 1'b1;
    end else if (shifted < SAT_MIN) begin
      rot = ROT_MIN;
      sat = 1'b1;
    end else begin
      rot = shifted[DATA_WIDTH-1:0];
      sat = 1'b0;
    end
  end

endmodule

/* src/quaternion_vector_rotate.sv */
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sample_t: quaternion and vector
// result    out        result_valid / result_stall  result_t: rotated vector, overflow
//
// Five register stages take one item in every cycle while the output is not stalled: the
// products of q and v, their sums into p = q * (0, v), the products of p and q, their sums,
// and the rounded and saturated output register. The edge that accepts an item loads stage
// one, and the item moves on through stages two to four to the output register, held until taken.
// Reset (rst, synchronous) empties every stage. A stage moves when it is empty or the
// stage after it moves, so bubbles close up while the output is stalled and nothing is lost.

module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_stall,
  input  sample_t sample,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Stage valid bits and advance enables.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage one: products of q and v, plus q carried along.
  quat_t                  s1_q;
  logic signed [QV_W-1:0] m_xx, m_yy, m_zz;
  logic signed [QV_W-1:0] m_wx, m_yz, m_zy;
  logic signed [QV_W-1:0] m_wy, m_xz, m_zx;
  logic signed [QV_W-1:0] m_wz, m_xy, m_yx;

  // Stage two: p = q * (0, v).
  quat_t                 s2_q;
  logic signed [P_W-1:0] p0, p1, p2, p3;

  // Stage three: products of p and q.
  logic signed [PQ_W-1:0] n_0x, n_1w, n_2z, n_3y;
  logic signed [PQ_W-1:0] n_0y, n_1z, n_2w, n_3x;
  logic signed [PQ_W-1:0] n_0z, n_1y, n_2x, n_3w;

  // Stage four: vector part of p * conj(q), still scaled by 2^OUT_SHIFT.
  logic signed [ACC_W-1:0] acc_x, acc_y, acc_z;

  // Rounding and saturation of stage four, captured by the output register.
  logic signed [DATA_WIDTH-1:0] rnd_x, rnd_y, rnd_z;
  logic                         sat_x, sat_y, sat_z;

  assign adv5 = !result_valid || !result_stall;
  assign adv4 = !s4_valid || adv5;
  assign adv3 = !s3_valid || adv4;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;

  assign sample_stall = !adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid <= sample_valid;
      end
      if (adv2) begin
        s2_valid <= s1_valid;
      end
      if (adv3) begin
        s3_valid <= s2_valid;
      end
      if (adv4) begin
        s4_valid <= s3_valid;
      end
      if (adv5) begin
        result_valid <= s4_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_q.w <= sample.quat_w;
      s1_q.x <= sample.quat_x;
      s1_q.y <= sample.quat_y;
      s1_q.z <= sample.quat_z;
      m_xx   <= sample.quat_x * sample.vec_x;
      m_yy   <= sample.quat_y * sample.vec_y;
      m_zz   <= sample.quat_z * sample.vec_z;
      m_wx   <= sample.quat_w * sample.vec_x;
      m_yz   <= sample.quat_y * sample.vec_z;
      m_zy   <= sample.quat_z * sample.vec_y;
      m_wy   <= sample.quat_w * sample.vec_y;
      m_xz   <= sample.quat_x * sample.vec_z;
      m_zx   <= sample.quat_z * sample.vec_x;
      m_wz   <= sample.quat_w * sample.vec_z;
      m_xy   <= sample.quat_x * sample.vec_y;
      m_yx   <= sample.quat_y * sample.vec_x;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_q <= s1_q;
      p0   <= -P_W'(m_xx) - P_W'(m_yy) - P_W'(m_zz);
      p1   <=  P_W'(m_wx) + P_W'(m_yz) - P_W'(m_zy);
      p2   <=  P_W'(m_wy) - P_W'(m_xz) + P_W'(m_zx);
      p3   <=  P_W'(m_wz) + P_W'(m_xy) - P_W'(m_yx);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      n_0x <= p0 * s2_q.x;
      n_1w <= p1 * s2_q.w;
      n_2z <= p2 * s2_q.z;
      n_3y <= p3 * s2_q.y;
      n_0y <= p0 * s2_q.y;
      n_1z <= p1 * s2_q.z;
      n_2w <= p2 * s2_q.w;
      n_3x <= p3 * s2_q.x;
      n_0z <= p0 * s2_q.z;
      n_1y <= p1 * s2_q.y;
      n_2x <= p2 * s2_q.x;
      n_3w <= p3 * s2_q.w;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      acc_x <= -ACC_W'(n_0x) + ACC_W'(n_1w) - ACC_W'(n_2z) + ACC_W'(n_3y);
      acc_y <= -ACC_W'(n_0y) + ACC_W'(n_1z) + ACC_W'(n_2w) - ACC_W'(n_3x);
      acc_z <= -ACC_W'(n_0z) - ACC_W'(n_1y) + ACC_W'(n_2x) + ACC_W'(n_3w);
    end
  end

  qvr_round_sat u_round_x (.acc(acc_x), .rot(rnd_x), .sat(sat_x));
  qvr_round_sat u_round_y (.acc(acc_y), .rot(rnd_y), .sat(sat_y));
  qvr_round_sat u_round_z (.acc(acc_z), .rot(rnd_z), .sat(sat_z));

  // The output register holds a stalled result while upstream stages keep filling.
  always_ff @(posedge clk) begin
    if (adv5) begin
      result.rot_x    <= rnd_x;
      result.rot_y    <= rnd_y;
      result.rot_z    <= rnd_z;
      result.overflow <= sat_x | sat_y | sat_z;
    end
  end

endmodule
